// File: rtl/core/dsd_pkg.sv
// Shared types and constants of the delimiter stream deframer.
// No dependencies; the window, top level, checker and bench refer to it by scoped names.
`timescale 1ns / 1ps

package dsd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 4;
	localparam int PAT_W  = 64;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	typedef enum logic {
		REG_DELIM_LEN = 1'b0,
		REG_DELIM_PAT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
	} in_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_valid;
		logic              message_end;
	} out_beat_t;

	typedef struct packed {
		logic      has;
		out_beat_t beat;
	} dsd_result_t;

endpackage

// File: rtl/core/dsd_chan_if.sv
// Valid/ready channel carrying one beat of a packed payload type.
// Used by the deframer for its byte input and its result output.
`timescale 1ns / 1ps

interface dsd_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/dsd_window.sv
// Delimiter match window: pending bytes, fill count, compare and shift.
// Depends on dsd_pkg for widths and the result struct.
`timescale 1ns / 1ps

module dsd_window #(
	parameter int MAX_DELIM_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       clear,
	input  logic [dsd_pkg::BYTE_W-1:0] stream_byte,
	input  logic [dsd_pkg::LEN_W-1:0]  delim_len,
	input  logic [dsd_pkg::PAT_W-1:0]  delim_pat,
	output dsd_pkg::dsd_result_t       result
);

	localparam int FILL_W = $clog2(MAX_DELIM_BYTES + 1);

	logic [dsd_pkg::BYTE_W-1:0] window_q [MAX_DELIM_BYTES];
	logic [dsd_pkg::BYTE_W-1:0] win      [MAX_DELIM_BYTES];
	logic [dsd_pkg::BYTE_W-1:0] next_w   [MAX_DELIM_BYTES];
	logic [FILL_W-1:0]          fill_q;
	logic [FILL_W-1:0]          eff_len;
	logic [FILL_W-1:0]          base;
	logic [FILL_W-1:0]          new_fill;
	logic                       full;
	logic                       hit;

	always_comb begin
		if (delim_len == '0) begin
			eff_len = FILL_W'(1);
		end else if (delim_len > dsd_pkg::LEN_W'(MAX_DELIM_BYTES)) begin
			eff_len = FILL_W'(MAX_DELIM_BYTES);
		end else begin
			eff_len = delim_len[FILL_W-1:0];
		end
	end

	assign base     = (fill_q >= eff_len) ? '0 : fill_q;
	assign new_fill = base + FILL_W'(1);
	assign full     = (new_fill == eff_len);

	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
			win[i] = (FILL_W'(i) == base) ? stream_byte : window_q[i];
			if ((FILL_W'(i) < eff_len) && (win[i] != delim_pat[i*dsd_pkg::BYTE_W +: dsd_pkg::BYTE_W]))
			begin
				hit = 1'b0;
			end
		end
	end

	for (genvar gi = 0; gi < MAX_DELIM_BYTES; gi++) begin : g_next
		if (gi < MAX_DELIM_BYTES - 1) begin : g_shift
			assign next_w[gi] = (full && !hit) ? win[gi+1] : win[gi];
		end else begin : g_last
			assign next_w[gi] = win[gi];
		end
	end

	always_comb begin
		result.has                = full;
		result.beat.message_end   = full && hit;
		result.beat.payload_valid = full && !hit;
		result.beat.payload_byte  = (full && !hit) ? win[0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (step) begin
			if (!full) begin
				fill_q <= new_fill;
			end else if (hit) begin
				fill_q <= '0;
			end else begin
				fill_q <= eff_len - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			window_q <= next_w;
		end
	end

endmodule

// File: rtl/core/delimiter_stream_deframer.sv
// Delimiter stream deframer top level: input register, match window, result register.
// Accepted bytes pass the input register and match window into the result register.
// Throughput: one byte per cycle; a byte giving no result leaves the input stage while a
// result waits, so only a stalled output plus a held byte with a result stops acceptance.
// Reset: asynchronous active low; empties both stages and the window, length 1, pattern 0x0A.
// Depends on dsd_pkg, dsd_chan_if and dsd_window.
`timescale 1ns / 1ps

module delimiter_stream_deframer #(
	parameter int MAX_DELIM_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dsd_pkg::ADDR_W-1:0] paddr,
	input  logic [dsd_pkg::DATA_W-1:0] pwdata,
	output logic [dsd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	dsd_chan_if.sink                   byte_in,
	dsd_chan_if.source                 msg_out
);

	logic [dsd_pkg::LEN_W-1:0]  delim_len_q;
	logic [dsd_pkg::PAT_W-1:0]  delim_pat_q;
	logic                       valid_s1;
	logic [dsd_pkg::BYTE_W-1:0] byte_s1;
	logic                       out_valid_q;
	dsd_pkg::out_beat_t         out_beat_q;
	dsd_pkg::dsd_result_t       result;
	dsd_pkg::in_beat_t          in_beat;
	dsd_pkg::reg_idx_t          reg_idx;
	logic                       cfg_wr;
	logic                       len_wr;
	logic                       adv_s1;
	logic                       accept;

	assign pready  = 1'b1;
	assign reg_idx = dsd_pkg::reg_idx_t'(paddr[dsd_pkg::ADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign len_wr  = cfg_wr && (reg_idx == dsd_pkg::REG_DELIM_LEN);

	always_comb begin
		case (reg_idx)
			dsd_pkg::REG_DELIM_LEN: prdata = dsd_pkg::DATA_W'(delim_len_q);
			dsd_pkg::REG_DELIM_PAT: prdata = dsd_pkg::DATA_W'(delim_pat_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_len_q <= dsd_pkg::LEN_W'(1);
			delim_pat_q <= dsd_pkg::PAT_W'(10);
		end else if (cfg_wr) begin
			case (reg_idx)
				dsd_pkg::REG_DELIM_LEN: delim_len_q <= pwdata[dsd_pkg::LEN_W-1:0];
				dsd_pkg::REG_DELIM_PAT: delim_pat_q <= pwdata[dsd_pkg::PAT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_beat       = byte_in.data;
	assign adv_s1        = valid_s1 && (!result.has || !out_valid_q || msg_out.ready);
	assign byte_in.ready = !valid_s1 || adv_s1;
	assign accept        = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_beat.stream_byte;
		end
	end

	dsd_window #(
		.MAX_DELIM_BYTES(MAX_DELIM_BYTES)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.clear      (len_wr),
		.stream_byte(byte_s1),
		.delim_len  (delim_len_q),
		.delim_pat  (delim_pat_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && result.has) begin
			out_valid_q <= 1'b1;
		end else if (msg_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && result.has) begin
			out_beat_q <= result.beat;
		end
	end

	assign msg_out.valid = out_valid_q;
	assign msg_out.data  = out_beat_q;

endmodule

// File: rtl/core/dsd_checker.sv
// Port-level checks for the delimiter stream deframer, attached by bind.
// Depends on dsd_pkg for widths and on the top level's port names.
`timescale 1ns / 1ps

module dsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [dsd_pkg::BYTE_W-1:0] payload_byte,
	input logic                       payload_valid,
	input logic                       message_end
);

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(payload_byte) && $stable(payload_valid) && $stable(message_end))
		else $error("result beat changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_valid ^ message_end))
		else $error("result beat is neither or both of payload and end");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> (payload_byte == '0))
		else $error("end beat carries a payload byte");

	// a fresh result is checked against an earlier accepted input beat
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input beat");

	a_backpress: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output free");

endmodule

bind delimiter_stream_deframer dsd_checker u_dsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_in.valid),
	.in_ready     (byte_in.ready),
	.out_valid    (msg_out.valid),
	.out_ready    (msg_out.ready),
	.payload_byte (msg_out.data.payload_byte),
	.payload_valid(msg_out.data.payload_valid),
	.message_end  (msg_out.data.message_end)
);

// File: bench/testbench.sv
// Self-checking bench for delimiter_stream_deframer: bytes in, payload and end markers out.
// A class keeps its own copy of the match window and the delimiter registers and predicts
// every result. Depends on dsd_pkg, dsd_chan_if and the deframer RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int PHASE_BYTES = 75;

	class frame_scoreboard;
		logic [7:0]          window [8];
		int                  fill;
		logic [3:0]          len_reg;
		logic [63:0]         pattern;
		dsd_pkg::out_beat_t  expected [$];
		int                  errors;

		function new();
			len_reg = 4'd1;
			pattern = 64'h0A;
			errors  = 0;
			clear_window();
		endfunction

		function void clear_window();
			foreach (window[i])
				window[i] = 8'h00;
			fill = 0;
		endfunction

		function int active_length();
			if (len_reg == 4'd0)
				return 1;
			if (len_reg > 4'd8)
				return 8;
			return int'(len_reg);
		endfunction

		function logic [7:0] delim_byte(int i);
			return pattern[8*i +: 8];
		endfunction

		function void write_reg(dsd_pkg::reg_idx_t idx, logic [63:0] value);
			if (idx == dsd_pkg::REG_DELIM_LEN) begin
				len_reg = value[3:0];
				clear_window();
			end else begin
				pattern = value;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			int                 len;
			bit                 hit;
			dsd_pkg::out_beat_t want;
			len = active_length();
			if (fill >= len)
				clear_window();
			window[fill] = b;
			fill++;
			if (fill < len)
				return;
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (window[i] != delim_byte(i))
					hit = 1'b0;
			if (hit) begin
				clear_window();
				want.payload_byte  = 8'h00;
				want.payload_valid = 1'b0;
				want.message_end   = 1'b1;
			end else begin
				want.payload_byte  = window[0];
				want.payload_valid = 1'b1;
				want.message_end   = 1'b0;
				for (int i = 0; i + 1 < len; i++)
					window[i] = window[i + 1];
				window[len - 1] = 8'h00;
				fill = len - 1;
			end
			expected.insert(expected.size(), want);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_beat(dsd_pkg::out_beat_t got);
			dsd_pkg::out_beat_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected beat %h/%b/%b", got.payload_byte,
					got.payload_valid, got.message_end));
				return;
			end
			want = expected.pop_front();
			if (got.payload_byte !== want.payload_byte)
				report($sformatf("payload_byte %h, want %h", got.payload_byte,
					want.payload_byte));
			if (got.payload_valid !== want.payload_valid)
				report($sformatf("payload_valid %b, want %b", got.payload_valid,
					want.payload_valid));
			if (got.message_end !== want.message_end)
				report($sformatf("message_end %b, want %b", got.message_end,
					want.message_end));
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [dsd_pkg::ADDR_W-1:0] paddr;
	logic [dsd_pkg::DATA_W-1:0] pwdata;
	logic [dsd_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	dsd_chan_if #(.payload_t(dsd_pkg::in_beat_t))  byte_ch ();
	dsd_chan_if #(.payload_t(dsd_pkg::out_beat_t)) result_ch ();

	delimiter_stream_deframer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.byte_in (byte_ch),
		.msg_out (result_ch)
	);

	frame_scoreboard sb = new();

	logic [7:0] stream_q [$];
	int         bytes_sent = 0;
	int         cycles     = 0;
	bit         tx_burst   = 1'b0;
	bit         rx_burst   = 1'b0;
	bit         rx_hold    = 1'b0;
	bit         rx_taken   = 1'b0;
	int         rx_stall   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped at cycle limit, %0d beats outstanding", sb.expected.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_beat(result_ch.data);
			rx_taken = 1'b1;
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall > 0)
				rx_stall--;
			if (rx_taken) begin
				rx_taken = 1'b0;
				rx_stall = rx_burst ? 0 : $urandom_range(0, 18);
			end
			if ($urandom_range(0, 299) == 0)
				rx_burst = !rx_burst;
			result_ch.ready <= !rx_hold && rx_stall == 0;
		end
	end

	// hold the output back long enough for the block to fill and stall its input
	initial begin
		wait (bytes_sent >= 450);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(negedge clk);
		rx_hold <= 1'b0;
	end

	function automatic void queue_byte(logic [7:0] b);
		stream_q.insert(stream_q.size(), b);
	endfunction

	task automatic reg_write(dsd_pkg::reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.data.stream_byte <= b;
		byte_ch.valid            <= 1'b1;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0)
			send_byte(stream_q.pop_front());
		byte_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (sb.expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// mostly delimiters, delimiter prefixes and delimiter bytes, a little noise
	task automatic fill_stream(int n);
		int len;
		int k;
		len = sb.active_length();
		while (stream_q.size() < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					for (int i = 0; i < len; i++)
						queue_byte(sb.delim_byte(i));
				end
				4, 5: begin
					k = $urandom_range(1, len);
					for (int i = 0; i < k; i++)
						queue_byte(sb.delim_byte(i));
					queue_byte(8'($urandom_range(0, 255)));
				end
				6, 7, 8: begin
					repeat ($urandom_range(1, 4))
						queue_byte(sb.delim_byte($urandom_range(0, len - 1)));
				end
				default: begin
					queue_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	initial begin
		logic [63:0] pat;
		logic [7:0]  b0;
		logic [7:0]  b1;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		stream_q = '{8'h00, 8'hFF, 8'h0A, 8'h0A, 8'h41};
		send_stream();
		settle();

		reg_write(dsd_pkg::REG_DELIM_LEN, 64'd0);
		reg_write(dsd_pkg::REG_DELIM_PAT, '1);
		stream_q = '{8'hFF, 8'h00, 8'h7F};
		send_stream();
		settle();

		reg_write(dsd_pkg::REG_DELIM_LEN, 64'd15);
		reg_write(dsd_pkg::REG_DELIM_PAT, 64'd0);
		stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
		send_stream();
		settle();

		reg_write(dsd_pkg::REG_DELIM_LEN, 64'd3);
		reg_write(dsd_pkg::REG_DELIM_PAT, 64'h0000_0000_000B_0A0A);
		stream_q = '{8'h0A, 8'h0A, 8'h0A, 8'h0B, 8'h0A};
		send_stream();
		settle();

		reg_write(dsd_pkg::REG_DELIM_PAT, 64'hDEAD_BEEF_000A_0B0A);
		stream_q = '{8'h0B, 8'h0A};
		send_stream();
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4 || $urandom_range(0, 3) != 0)
				case (p)
					0:       reg_write(dsd_pkg::REG_DELIM_LEN, 64'd8);
					1:       reg_write(dsd_pkg::REG_DELIM_LEN, 64'd1);
					2:       reg_write(dsd_pkg::REG_DELIM_LEN, 64'd9);
					3:       reg_write(dsd_pkg::REG_DELIM_LEN, 64'd2);
					default: reg_write(dsd_pkg::REG_DELIM_LEN, 64'($urandom_range(0, 15)));
				endcase
			b0 = 8'($urandom_range(0, 255));
			b1 = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 4))
				0, 1: pat = {$urandom, $urandom};
				2:    pat = {8{b0}};
				3:    pat = {4{b1, b0}};
				default: pat = $urandom_range(0, 1) ? '1 : '0;
			endcase
			reg_write(dsd_pkg::REG_DELIM_PAT, pat);
			tx_burst = $urandom_range(0, 3) == 0;
			fill_stream(PHASE_BYTES);
			send_stream();
			settle();
		end

		tx_burst = 1'b0;
		settle();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/dsd_pkg.sv
rtl/core/dsd_chan_if.sv
rtl/core/dsd_window.sv
rtl/core/delimiter_stream_deframer.sv
rtl/core/dsd_checker.sv
bench/testbench.sv
